// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the block's modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define SRM_ASSERT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("srm assertion failed");

// Next-cycle implication, disabled while reset is held.
`define SRM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("srm assertion failed");

`endif

// ===== rtl/srm_pkg.sv =====
package srm_pkg;

    localparam int LOG_TABLE_BITS_DEF = 8;
    localparam int FRAC_BITS_DEF      = 16;

    localparam int DATA_W    = 32;
    localparam int DEN_W     = DATA_W + 1;   // |end - start|
    localparam int IW        = 30;           // table fraction bits
    localparam int SKEW_W    = 24;
    localparam int SKEW_FRAC = 16;
    localparam logic [SKEW_W-1:0] SKEW_ONE = 24'h01_0000;

    localparam int LOG_BITS_MAX = 12;
    localparam int TAB_MAX      = 1 << LOG_BITS_MAX;
    localparam int TAB_IW       = LOG_BITS_MAX + 1;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SKEW        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMMETRIC   = 2'd3;

    typedef logic [31:0] t_tab [0:TAB_MAX];

    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] bt;
        v  = val;
        r  = '0;
        bt = 64'd1 << 62;
        while (bt > v) bt = bt >> 2;
        while (bt != 64'd0) begin
            if (v >= r + bt) begin
                v = v - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt = bt >> 2;
        end
        return r;
    endfunction

    // log2(1 + i/n) in Q2.30, by repeated squaring
    function automatic t_tab log_table(input int lbits);
        t_tab        tab;
        logic [63:0] m;
        logic [63:0] lg;
        int          n;
        tab = '{default: '0};
        n   = 1 << lbits;
        for (int i = 0; i < n; i++) begin
            m  = (64'd1 << IW) + (64'(i) << (IW - lbits));
            lg = '0;
            for (int j = 0; j < IW; j++) begin
                m = (m * m) >> IW;
                if (m >= (64'd2 << IW)) begin
                    lg = lg | (64'd1 << (IW - 1 - j));
                    m  = m >> 1;
                end
            end
            tab[i] = lg[31:0];
        end
        tab[n] = 32'(64'd1 << IW);
        return tab;
    endfunction

    // 2^(i/n) in Q2.30, from products of repeated square roots of two
    function automatic t_tab exp_table(input int lbits);
        t_tab        tab;
        logic [63:0] roots [0:LOG_BITS_MAX];
        logic [63:0] acc;
        int          n;
        tab = '{default: '0};
        roots = '{default: '0};
        n   = 1 << lbits;
        roots[0] = 64'd2 << IW;
        for (int j = 1; j <= lbits; j++) roots[j] = isqrt64(roots[j-1] << IW);
        for (int i = 0; i < n; i++) begin
            acc = 64'd1 << IW;
            for (int j = 1; j <= lbits; j++) begin
                if (((i >> (lbits - j)) & 1) != 0) acc = (acc * roots[j]) >> IW;
            end
            tab[i] = acc[31:0];
        end
        tab[n] = 32'(64'd2 << IW);
        return tab;
    endfunction

endpackage

// ===== rtl/srm_div.sv =====
`include "assert_macros.svh"

// Restoring divider, one quotient bit per stage: floor(rem * 2^F / den), rem < den.
module srm_div #(
    parameter int FRAC_BITS = srm_pkg::FRAC_BITS_DEF,
    parameter int TAG_W     = 2
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  logic [srm_pkg::DEN_W-1:0] i_rem,
    input  logic [srm_pkg::DEN_W-1:0] i_den,
    input  logic [TAG_W-1:0]          i_tag,
    output logic                      o_valid,
    output logic [FRAC_BITS-1:0]      o_quo,
    output logic [TAG_W-1:0]          o_tag
);

    localparam int DW = srm_pkg::DEN_W;

    logic [FRAC_BITS-1:0] r_vld;
    logic [DW-1:0]        r_rem [FRAC_BITS];
    logic [FRAC_BITS-1:0] r_quo [FRAC_BITS];
    logic [TAG_W-1:0]     r_tag [FRAC_BITS];

    logic [DW:0]          n_step [FRAC_BITS];

    function automatic logic [DW:0] div_step(input logic [DW-1:0] rem,
                                             input logic [DW-1:0] den);
        logic [DW:0] dbl;
        dbl = {rem, 1'b0};
        if (dbl >= {1'b0, den}) return {1'b1, DW'(dbl - {1'b0, den})};
        return {1'b0, dbl[DW-1:0]};
    endfunction

    always_comb begin
        n_step[0] = div_step(i_rem, i_den);
        for (int k = 1; k < FRAC_BITS; k++) n_step[k] = div_step(r_rem[k-1], i_den);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[FRAC_BITS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_step[0][DW-1:0];
            r_quo[0] <= {{(FRAC_BITS-1){1'b0}}, n_step[0][DW]};
            r_tag[0] <= i_tag;
            for (int k = 1; k < FRAC_BITS; k++) begin
                r_rem[k] <= n_step[k][DW-1:0];
                r_quo[k] <= {r_quo[k-1][FRAC_BITS-2:0], n_step[k][DW]};
                r_tag[k] <= r_tag[k-1];
            end
        end
    end

    assign o_valid = r_vld[FRAC_BITS-1];
    assign o_quo   = r_quo[FRAC_BITS-1];
    assign o_tag   = r_tag[FRAC_BITS-1];

    `SRM_ASSERT(a_rem_below_den, i_clk, i_rst_n, r_vld[FRAC_BITS-1] && (i_den != '0), r_rem[FRAC_BITS-1] < i_den)
    `SRM_ASSERT_NEXT(a_frozen_on_stall, i_clk, i_rst_n, !i_en, $stable(r_vld))

endmodule

// ===== rtl/srm_pow.sv =====
`include "assert_macros.svh"

// x^skew = 2^(-skew * |log2 x|) for x in 0..1 (QF), eight stages.
module srm_pow #(
    parameter int LOG_TABLE_BITS = srm_pkg::LOG_TABLE_BITS_DEF,
    parameter int FRAC_BITS      = srm_pkg::FRAC_BITS_DEF,
    parameter int TAG_W          = 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic [srm_pkg::SKEW_W-1:0] i_skew,
    input  logic                       i_valid,
    input  logic [FRAC_BITS:0]         i_x,
    input  logic [TAG_W-1:0]           i_tag,
    output logic                       o_valid,
    output logic [FRAC_BITS:0]         o_pw,
    output logic [TAG_W-1:0]           o_tag
);

    localparam int IW   = srm_pkg::IW;
    localparam int PW   = FRAC_BITS + 1;
    localparam int BW   = $clog2(FRAC_BITS + 1);
    localparam int SH   = IW - LOG_TABLE_BITS;
    localparam int MW   = IW + BW;
    localparam int AW   = MW + srm_pkg::SKEW_W - srm_pkg::SKEW_FRAC;
    localparam int NW   = AW - IW;
    localparam int PRW  = 32 + SH;
    localparam int EXP_BASE = IW - FRAC_BITS + 1;
    localparam int NSTG = 8;
    localparam logic [PW-1:0] PONE = {1'b1, {FRAC_BITS{1'b0}}};

    localparam srm_pkg::t_tab LOG_TAB = srm_pkg::log_table(LOG_TABLE_BITS);
    localparam srm_pkg::t_tab EXP_TAB = srm_pkg::exp_table(LOG_TABLE_BITS);

    typedef enum logic [1:0] {
        POW_CALC   = 2'd0,
        POW_ZERO   = 2'd1,
        POW_ONE    = 2'd2,
        POW_DIRECT = 2'd3
    } t_kind;

    logic [NSTG-1:0]  r_vld;
    logic [TAG_W-1:0] r_tag [NSTG];

    // stage 1: normalize
    t_kind            r1_kind;
    logic [BW-1:0]    r1_b;
    logic [IW-1:0]    r1_f;
    // stage 2: log table read
    t_kind            r2_kind;
    logic [BW-1:0]    r2_b;
    logic [31:0]      r2_t0, r2_dif;
    logic [SH-1:0]    r2_rem;
    // stage 3: log interpolation product
    t_kind            r3_kind;
    logic [BW-1:0]    r3_b;
    logic [31:0]      r3_t0;
    logic [PRW-1:0]   r3_prod;
    // stage 4: |log2 x|
    t_kind            r4_kind;
    logic [MW-1:0]    r4_mag;
    // stage 5: exponent product
    t_kind            r5_kind;
    logic [AW-1:0]    r5_a;
    // stage 6: exp table read
    t_kind            r6_kind;
    logic [NW-1:0]    r6_n;
    logic [PW-1:0]    r6_dv;
    logic [31:0]      r6_t0, r6_dif;
    logic [SH-1:0]    r6_rem;
    // stage 7: exp interpolation product
    t_kind            r7_kind;
    logic [NW-1:0]    r7_n;
    logic [PW-1:0]    r7_dv;
    logic [31:0]      r7_t0;
    logic [PRW-1:0]   r7_prod;
    // stage 8: result
    logic [PW-1:0]    r8_pw;

    t_kind                  n1_kind;
    logic [BW-1:0]          n1_b;
    logic [IW+FRAC_BITS-1:0] n1_sh;
    logic [LOG_TABLE_BITS-1:0] n2_idx;
    logic [srm_pkg::TAB_IW-1:0] n2_i0, n6_i0;
    logic [31:0]            n4_lg;
    logic [BW-1:0]          n4_fb;
    logic [srm_pkg::SKEW_W+MW-1:0] n5_prod;
    logic [IW-1:0]          n6_fr;
    logic [IW:0]            n6_f2;
    logic [LOG_TABLE_BITS-1:0] n6_idx;
    t_kind                  n6_kind;
    logic [PW-1:0]          n6_dv;
    logic [31:0]            n8_v;
    logic [NW:0]            n8_sh;
    logic [PW-1:0]          n8_pw;

    always_comb begin
        n1_b = '0;
        for (int k = 0; k < FRAC_BITS; k++) begin
            if (i_x[k]) n1_b = BW'(k);
        end
        if (i_x[FRAC_BITS]) n1_kind = POW_ONE;
        else if (i_x == '0) n1_kind = POW_ZERO;
        else n1_kind = POW_CALC;
        n1_sh = (IW+FRAC_BITS)'(i_x[FRAC_BITS-1:0]) << (IW - int'(n1_b));
    end

    assign n2_idx = r1_f[IW-1:SH];
    assign n2_i0  = srm_pkg::TAB_IW'(n2_idx);

    assign n4_lg = r3_t0 + 32'(r3_prod >> SH);
    assign n4_fb = BW'(FRAC_BITS) - r3_b;

    assign n5_prod = i_skew * r4_mag;

    always_comb begin
        n6_fr  = r5_a[IW-1:0];
        n6_f2  = ((IW+1)'(1) << IW) - (IW+1)'(n6_fr);
        n6_idx = n6_f2[IW-1:SH];
        n6_i0  = srm_pkg::TAB_IW'(n6_idx);
        n6_kind = r5_kind;
        n6_dv  = '0;
        if (r5_kind == POW_CALC && n6_fr == '0) begin
            n6_kind = POW_DIRECT;
            n6_dv   = (r5_a[AW-1:IW] > NW'(FRAC_BITS)) ? '0 : (PONE >> r5_a[AW-1:IW]);
        end
    end

    always_comb begin
        n8_v  = r7_t0 + 32'(r7_prod >> SH);
        n8_sh = (NW+1)'(r7_n) + (NW+1)'(EXP_BASE);
        case (r7_kind)
            POW_CALC:   n8_pw = PW'(n8_v >> n8_sh);
            POW_ZERO:   n8_pw = '0;
            POW_ONE:    n8_pw = PONE;
            POW_DIRECT: n8_pw = r7_dv;
            default:    n8_pw = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            for (int k = 1; k < NSTG; k++) r_tag[k] <= r_tag[k-1];

            r1_kind <= n1_kind;
            r1_b    <= n1_b;
            r1_f    <= n1_sh[IW-1:0];

            r2_kind <= r1_kind;
            r2_b    <= r1_b;
            r2_t0   <= LOG_TAB[n2_i0];
            r2_dif  <= LOG_TAB[n2_i0 + srm_pkg::TAB_IW'(1)] - LOG_TAB[n2_i0];
            r2_rem  <= r1_f[SH-1:0];

            r3_kind <= r2_kind;
            r3_b    <= r2_b;
            r3_t0   <= r2_t0;
            r3_prod <= r2_dif * r2_rem;

            r4_kind <= r3_kind;
            r4_mag  <= {n4_fb, {IW{1'b0}}} - MW'(n4_lg);

            r5_kind <= r4_kind;
            r5_a    <= n5_prod[srm_pkg::SKEW_W+MW-1:srm_pkg::SKEW_FRAC];

            r6_kind <= n6_kind;
            r6_n    <= r5_a[AW-1:IW];
            r6_dv   <= n6_dv;
            r6_t0   <= EXP_TAB[n6_i0];
            r6_dif  <= EXP_TAB[n6_i0 + srm_pkg::TAB_IW'(1)] - EXP_TAB[n6_i0];
            r6_rem  <= n6_f2[SH-1:0];

            r7_kind <= r6_kind;
            r7_n    <= r6_n;
            r7_dv   <= r6_dv;
            r7_t0   <= r6_t0;
            r7_prod <= r6_dif * r6_rem;

            r8_pw   <= n8_pw;
        end
    end

    assign o_valid = r_vld[NSTG-1];
    assign o_pw    = r8_pw;
    assign o_tag   = r_tag[NSTG-1];

    `SRM_ASSERT(a_pow_at_most_one, i_clk, i_rst_n, o_valid, o_pw <= PONE)

endmodule

// ===== rtl/skewed_range_map.sv =====
// skewed_range_map: maps one signed Q16.16 value per request onto a skewed
// curve within range_start..range_end.
//
// Input stream  (i_s_*): one value per request, taken when tvalid && tready.
// Output stream (o_m_*): mapped value in tdata, degenerate-range flag in tuser.
// Config channel (i_cfg_*): index 0 start, 1 end, 2 skew (Q8.16), 3 symmetric.
//   Always ready; write only while no request is in flight.
//
// The pipe has three setup stages, one divider stage per proportion bit, one
// fold stage, eight stages of the log/exp power unit and three stages of
// curve select, scale and offset. It takes one request per cycle while the
// receiver is not stalling.
//
// Reset (synchronous, active low) restores the register defaults and clears
// every valid bit; the power tables are constants and need no fill.
// When the receiver stalls, the whole pipe freezes in place and o_s_tready
// falls until the output register drains; bubbles in flight are not lost.
`include "assert_macros.svh"

module skewed_range_map #(
    parameter int LOG_TABLE_BITS = srm_pkg::LOG_TABLE_BITS_DEF,
    parameter int FRAC_BITS      = srm_pkg::FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [31:0]                   i_s_tdata,    // [31:0] in_value
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [31:0]                   o_m_tdata,    // [31:0] mapped_value
    output logic                          o_m_tuser,    // [0] degenerate_range
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [srm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                   i_cfg_data
);

    localparam int DW = srm_pkg::DEN_W;
    localparam int PW = FRAC_BITS + 1;
    localparam logic [PW-1:0] PONE = {1'b1, {FRAC_BITS{1'b0}}};

    // config registers and values derived from them
    logic [31:0]                 r_start, r_end;
    logic [srm_pkg::SKEW_W-1:0]  r_skew;
    logic                        r_sym;
    logic [DW-1:0]               r_dmag;    // |end - start|
    logic                        r_dneg;    // end < start
    logic                        r_deg;     // end == start
    logic [DW-1:0]               n_span;

    logic en;

    // setup stages
    logic                r0_vld, r1_vld, r2_vld;
    logic [DW-1:0]       r0_num;            // in - start, signed
    logic [DW:0]         r1_nn;             // sign-corrected numerator
    logic [DW-1:0]       r2_rem;
    logic [1:0]          r2_cls;            // {clamp high, clamp low}
    logic                n2_zero, n2_one;

    // divider
    logic                div_vld;
    logic [FRAC_BITS-1:0] div_quo;
    logic [1:0]          div_cls;

    // proportion / symmetric fold
    logic                r3_vld;
    logic [PW-1:0]       r3_p, r3_x;
    logic                r3_neg;
    logic [PW-1:0]       n3_p;
    logic [PW:0]         n3_d;
    logic [PW:0]         n3_dm;

    // power unit
    logic                pw_vld;
    logic [PW-1:0]       pw_val;
    logic [PW:0]         pw_tag;

    // curve, scale, output
    logic                r4_vld, r5_vld;
    logic [PW-1:0]       r4_curve, n4_curve, n4_pe;
    logic [PW:0]         n4_sum;
    logic [DW+PW-1:0]    r5_prod;
    logic [31:0]         n6_scaled;
    logic                r_o_valid;
    logic [31:0]         r_o_data;
    logic                r_o_user;

    // output lies between start and end, whichever way the range runs
    logic                out_in_range;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 32'd0;
            r_end   <= 32'd65536;
            r_skew  <= srm_pkg::SKEW_ONE;
            r_sym   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                srm_pkg::CFG_RANGE_START: r_start <= i_cfg_data;
                srm_pkg::CFG_RANGE_END:   r_end   <= i_cfg_data;
                srm_pkg::CFG_SKEW:        r_skew  <= i_cfg_data[srm_pkg::SKEW_W-1:0];
                srm_pkg::CFG_SYMMETRIC:   r_sym   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // the user must keep the span static while requests are in flight; the block
    // does not enforce it. The lag of the registered span is covered by the setup stages
    assign n_span = {r_end[31], r_end} - {r_start[31], r_start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dmag <= DW'(65536);
            r_dneg <= 1'b0;
            r_deg  <= 1'b0;
        end else begin
            r_dmag <= n_span[DW-1] ? -n_span : n_span;
            r_dneg <= n_span[DW-1];
            r_deg  <= (r_start == r_end);
        end
    end

    // one shared advance: everything moves unless the output is held
    assign en         = ~r_o_valid | i_m_tready;
    assign o_s_tready = en;

    // clamp classification
    assign n2_zero = r1_nn[DW] | (r1_nn == '0);
    assign n2_one  = ~n2_zero & (r1_nn[DW-1:0] >= r_dmag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
        end else if (en) begin
            r0_vld <= i_s_tvalid;
            r1_vld <= r0_vld;
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_num <= {i_s_tdata[31], i_s_tdata} - {r_start[31], r_start};
            r1_nn  <= r_dneg ? -{r0_num[DW-1], r0_num} : {r0_num[DW-1], r0_num};
            r2_rem <= (n2_zero | n2_one) ? '0 : r1_nn[DW-1:0];
            r2_cls <= {n2_one, n2_zero};
        end
    end

    srm_div #(
        .FRAC_BITS (FRAC_BITS),
        .TAG_W     (2)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r2_vld),
        .i_rem   (r2_rem),
        .i_den   (r_dmag),
        .i_tag   (r2_cls),
        .o_valid (div_vld),
        .o_quo   (div_quo),
        .o_tag   (div_cls)
    );

    // proportion, then fold about the midpoint in symmetric mode
    always_comb begin
        if (div_cls[0]) n3_p = '0;
        else if (div_cls[1]) n3_p = PONE;
        else n3_p = {1'b0, div_quo};
        n3_d  = {n3_p, 1'b0} - (PW+1)'(PONE);
        n3_dm = n3_d[PW] ? -n3_d : n3_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_p   <= n3_p;
            r3_x   <= r_sym ? n3_dm[PW-1:0] : n3_p;
            r3_neg <= r_sym & n3_d[PW];
        end
    end

    srm_pow #(
        .LOG_TABLE_BITS (LOG_TABLE_BITS),
        .FRAC_BITS      (FRAC_BITS),
        .TAG_W          (PW + 1)
    ) u_pow (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_skew  (r_skew),
        .i_valid (r3_vld),
        .i_x     (r3_x),
        .i_tag   ({r3_neg, r3_p}),
        .o_valid (pw_vld),
        .o_pw    (pw_val),
        .o_tag   (pw_tag)
    );

    // curve select: linear skew bypasses the power, zero skew forces the power term to one
    always_comb begin
        n4_pe  = (r_skew == '0) ? PONE : pw_val;
        n4_sum = pw_tag[PW] ? ((PW+1)'(PONE) - (PW+1)'(n4_pe))
                            : ((PW+1)'(PONE) + (PW+1)'(n4_pe));
        if (r_skew == srm_pkg::SKEW_ONE) n4_curve = pw_tag[PW-1:0];
        else if (!r_sym) n4_curve = n4_pe;
        else n4_curve = n4_sum[PW:1];
    end

    assign n6_scaled = r5_prod[FRAC_BITS +: 32];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld    <= 1'b0;
            r5_vld    <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r4_vld    <= pw_vld;
            r5_vld    <= r4_vld;
            r_o_valid <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_curve <= n4_curve;
            r5_prod  <= r_dmag * r4_curve;
            if (r_deg) r_o_data <= r_start;
            else if (r_dneg) r_o_data <= r_start - n6_scaled;
            else r_o_data <= r_start + n6_scaled;
            r_o_user <= r_deg;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;
    assign o_m_tuser  = r_o_user;

    always_comb begin
        if (r_dneg) begin
            out_in_range = ($signed(o_m_tdata) <= $signed(r_start)) &&
                           ($signed(o_m_tdata) >= $signed(r_end));
        end else begin
            out_in_range = ($signed(o_m_tdata) >= $signed(r_start)) &&
                           ($signed(o_m_tdata) <= $signed(r_end));
        end
    end

    `SRM_ASSERT(a_degenerate_gives_start, i_clk, i_rst_n, o_m_tvalid && o_m_tuser, o_m_tdata == r_start)
    `SRM_ASSERT(a_result_within_range, i_clk, i_rst_n, o_m_tvalid && !o_m_tuser, out_in_range)

endmodule
